/* src/vmroc_pkg.sv */
// shared types and constants of the vector magnitude reporter
package vmroc_pkg;

    // field widths
    localparam int AXIS_W  = 15;
    localparam int MAG_W   = 15;
    localparam int THR_W   = 15;
    localparam int INTV_W  = 20;
    localparam int CAUSE_W = 2;
    localparam int SUM_W   = 2 * AXIS_W;
    localparam int CFG_W   = INTV_W;

    // timer compare width, covers the widest supported timer plus one bit
    localparam int CMP_W = 33;

    // serial step counts
    localparam int MUL_STEPS  = AXIS_W;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int STEP_CNT_W = 4;

    // register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(200);
    localparam logic [INTV_W-1:0] INTV_RESET = INTV_W'(900000);

    // register indexes
    localparam logic CFG_IDX_THRESHOLD = 1'b0;
    localparam logic CFG_IDX_INTERVAL  = 1'b1;

    // request kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // publish causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_CHANGE   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_INTERVAL = 2'd2;

    // largest magnitude the axes can produce
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(28377);

endpackage

/* src/vmroc_if.sv */
// request and result channel interfaces
interface vmroc_in_if
    import vmroc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;

    modport source (output valid, action, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, action, axis_x, axis_y, axis_z, output ready);
endinterface

interface vmroc_out_if
    import vmroc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   magnitude;
    logic               publish;
    logic [CAUSE_W-1:0] cause;

    modport source (output valid, magnitude, publish, cause, input ready);
    modport sink   (input valid, magnitude, publish, cause, output ready);
endinterface

/* src/vector_magnitude_report_on_change_top.sv */
// top level of the vector magnitude send-on-delta reporter
//
// channel   direction  payload
// item      in         action, axis_x, axis_y, axis_z
// result    out        magnitude, publish, cause
// cfg_*     in         cfg_we, cfg_index, cfg_data (write only)
//
// a sample loads on its accepting edge and its result becomes valid after these steps:
// 15 squaring steps, the root load, 15 root steps, the step into the decision state
// and the handoff into the result register; the next request is taken in the cycle
// after that handoff; a tick is handled on its accepting edge
// one request is in work at a time; a new request is taken while a result waits
// a sample holds in its decision cycle until the result register is free
// reset is asynchronous and active low and clears control and state registers
module vector_magnitude_report_on_change_top
    import vmroc_pkg::*;
#(
    parameter int TIMER_WIDTH = 21
)
(
    input  logic             clk,
    input  logic             rst_n,
    vmroc_in_if.sink         item,
    vmroc_out_if.source      result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ROOT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((64'd1 << TIMER_WIDTH) - 64'd1);

    state_t                 state_reg, state_next;
    logic [THR_W-1:0]       thr_reg;
    logic [INTV_W-1:0]      intv_reg;
    logic [MAG_W-1:0]       last_mag_reg;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic                   out_valid_reg;
    logic [MAG_W-1:0]       out_mag_reg;
    logic [CAUSE_W-1:0]     out_cause_reg;

    logic               accept;
    logic               take_tick;
    logic               sq_start, sq_done, rt_start, rt_done;
    logic [SUM_W-1:0]   sq_sum;
    logic [MAG_W-1:0]   rt_root;
    logic               emit;
    logic [MAG_W-1:0]   diff;
    logic [CMP_W-1:0]   cap;
    logic [CMP_W-1:0]   elapsed_ext;
    logic [CAUSE_W-1:0] cause;

    assign accept    = item.valid && item.ready;
    assign take_tick = accept && (item.action == ACT_TICK);
    assign sq_start  = accept && (item.action == ACT_SAMPLE);
    assign rt_start  = (state_reg == S_MUL) && sq_done;
    assign emit      = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // squaring and root units
    vmroc_sqsum u_sqsum (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .axis_x (item.axis_x),
        .axis_y (item.axis_y),
        .axis_z (item.axis_z),
        .done   (sq_done),
        .sum    (sq_sum)
    );

    vmroc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (sq_sum),
        .done     (rt_done),
        .root     (rt_root)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sq_start)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (sq_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (rt_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // publish decision
    always_comb
    begin
        diff        = (rt_root >= last_mag_reg) ? MAG_W'(rt_root - last_mag_reg)
                                                : MAG_W'(last_mag_reg - rt_root);
        elapsed_ext = CMP_W'(elapsed_reg);
        cap         = CMP_W'(intv_reg) + 1'b1;
        if (cap > TIMER_MAX)
        begin
            cap = TIMER_MAX;
        end
        if (diff >= thr_reg)
        begin
            cause = CAUSE_CHANGE;
        end
        else if (elapsed_ext > CMP_W'(intv_reg))
        begin
            cause = CAUSE_INTERVAL;
        end
        else
        begin
            cause = CAUSE_NONE;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= THR_RESET;
            intv_reg      <= INTV_RESET;
            last_mag_reg  <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_THRESHOLD: thr_reg  <= THR_W'(cfg_data);
                    CFG_IDX_INTERVAL:  intv_reg <= cfg_data;
                    default:           thr_reg  <= thr_reg;
                endcase
            end

            if (take_tick && (elapsed_ext < cap))
            begin
                elapsed_reg <= elapsed_reg + 1'b1;
            end

            if (emit && (cause != CAUSE_NONE))
            begin
                last_mag_reg <= rt_root;
                elapsed_reg  <= '0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_mag_reg   <= rt_root;
            out_cause_reg <= cause;
        end
    end

    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.magnitude = out_mag_reg;
    assign result.cause     = out_cause_reg;
    assign result.publish   = (out_cause_reg != CAUSE_NONE);

endmodule

/* src/vmroc_sqsum.sv */
// bit-serial sum of the three squared axes
module vmroc_sqsum
    import vmroc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AXIS_W-1:0] axis_x,
    input  logic [AXIS_W-1:0] axis_y,
    input  logic [AXIS_W-1:0] axis_z,
    output logic              done,
    output logic [SUM_W-1:0]  sum
);

    localparam int HI_W = AXIS_W + 2;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [AXIS_W-1:0]     ax_reg, ay_reg, az_reg;
    logic [AXIS_W-1:0]     mx_reg, my_reg, mz_reg;
    logic [HI_W-1:0]       hi_reg;
    logic [AXIS_W-1:0]     lo_reg;

    logic [AXIS_W-1:0] abs_x, abs_y, abs_z;
    logic [HI_W-1:0]   hi_sum;
    logic              last_step;

    // magnitudes of the signed axes
    always_comb
    begin
        abs_x = axis_x[AXIS_W-1] ? AXIS_W'(~axis_x + 1'b1) : axis_x;
        abs_y = axis_y[AXIS_W-1] ? AXIS_W'(~axis_y + 1'b1) : axis_y;
        abs_z = axis_z[AXIS_W-1] ? AXIS_W'(~axis_z + 1'b1) : axis_z;
    end

    // add the multiplicands selected by the current multiplier bits
    always_comb
    begin
        hi_sum = hi_reg
               + (mx_reg[0] ? HI_W'(ax_reg) : '0)
               + (my_reg[0] ? HI_W'(ay_reg) : '0)
               + (mz_reg[0] ? HI_W'(az_reg) : '0);
        last_step = (cnt_reg == STEP_CNT_W'(MUL_STEPS - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: one multiplier bit per cycle, partial product shifts right
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ax_reg <= abs_x;
            ay_reg <= abs_y;
            az_reg <= abs_z;
            mx_reg <= abs_x;
            my_reg <= abs_y;
            mz_reg <= abs_z;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            mx_reg <= mx_reg >> 1;
            my_reg <= my_reg >> 1;
            mz_reg <= mz_reg >> 1;
            hi_reg <= hi_sum >> 1;
            lo_reg <= {hi_sum[0], lo_reg[AXIS_W-1:1]};
        end
    end

    assign done = done_reg;
    assign sum  = SUM_W'({hi_reg, lo_reg});

endmodule

/* src/vmroc_isqrt.sv */
// digit-by-digit floor square root, one result bit per cycle
module vmroc_isqrt
    import vmroc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] radicand,
    output logic             done,
    output logic [MAG_W-1:0] root
);

    localparam int REM_W = MAG_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [MAG_W-1:0]      root_reg;

    logic [TRY_W-1:0] rem_sh;
    logic [TRY_W-1:0] trial;
    logic             fits;
    logic             last_step;

    // bring down two radicand bits and test the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SUM_W-1 -: 2]};
        trial     = TRY_W'({root_reg, 2'b01});
        fits      = (rem_sh >= trial);
        last_step = (cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/vmroc_checker.sv */
// port-level checks of the reporter, bound to the top level
module vmroc_checker
    import vmroc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_action,
    input logic               out_valid,
    input logic               out_ready,
    input logic [MAG_W-1:0]   out_magnitude,
    input logic               out_publish,
    input logic [CAUSE_W-1:0] out_cause
);

    // publish flag agrees with the cause
    a_publish_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_publish == (out_cause != CAUSE_NONE)))
        else $error("publish flag disagrees with cause");

    // magnitude stays within what three axes can give
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_magnitude <= MAG_MAX))
        else $error("magnitude out of range");

    // a sample keeps the request side busy in the next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_action == ACT_SAMPLE)) |=> !in_ready)
        else $error("request taken while a sample is in work");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_magnitude) && $stable(out_cause)))
        else $error("stalled result changed");

endmodule

bind vector_magnitude_report_on_change_top vmroc_checker u_vmroc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .in_action     (item.action),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_magnitude (result.magnitude),
    .out_publish   (result.publish),
    .out_cause     (result.cause)
);
